// ===== rtl/cpd_pkg.sv =====
// shared constants and channel interface types for the coil pulse driver
// no dependencies
package cpd_pkg;

  localparam int unsigned NumCoils = 6;
  localparam int unsigned CntW     = 16;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned QuietW   = 2;
  localparam int unsigned QuietChans = 2;

  localparam logic [QuietW-1:0]  QuietBlock = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgPulseTicks   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldoffTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgQuietMode    = 2'd2;

  localparam logic KindTick = 1'b0;
  localparam logic KindFire = 1'b1;

  localparam logic [CntW-1:0] PulseTicksRst   = 16'd10;
  localparam logic [CntW-1:0] HoldoffTicksRst = 16'd25;

  typedef struct packed {
    logic step;
    logic tick;
    logic fire;
    logic blocked;
  } cpd_chan_ctrl_t;

  typedef struct packed {
    logic drive;
    logic active;
    logic accepted;
  } cpd_chan_stat_t;

endpackage

// ===== rtl/cpd_chan.sv =====
// one coil channel: pulse countdown, holdoff elapsed count and drive bit
// depends on cpd_pkg
module cpd_chan import cpd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpd_chan_ctrl_t ctrl_i,
  input  logic [CntW-1:0] pulse_ticks_i,
  input  logic [CntW-1:0] holdoff_ticks_i,
  output cpd_chan_stat_t stat_o
);

  logic [CntW-1:0] left_q, left_d;
  logic [CntW-1:0] since_q, since_d;
  logic            active_q, active_d;
  logic            drive_q, drive_d;
  logic            accept;

  assign accept = ctrl_i.fire && (since_q >= holdoff_ticks_i);

  always_comb begin
    left_d   = left_q;
    since_d  = since_q;
    active_d = active_q;
    drive_d  = drive_q;
    if (ctrl_i.tick) begin
      if (since_q != {CntW{1'b1}}) begin
        since_d = since_q + CntW'(1);
      end
      if (active_q) begin
        if (left_q == '0) begin
          active_d = 1'b0;
          if (!ctrl_i.blocked) begin
            drive_d = 1'b0;
          end
        end else begin
          left_d = left_q - CntW'(1);
        end
      end
    end else if (accept) begin
      since_d  = '0;
      left_d   = pulse_ticks_i;
      active_d = 1'b1;
      if (!ctrl_i.blocked) begin
        drive_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      since_q  <= '0;
      active_q <= 1'b0;
      drive_q  <= 1'b0;
    end else if (ctrl_i.step) begin
      left_q   <= left_d;
      since_q  <= since_d;
      active_q <= active_d;
      drive_q  <= drive_d;
    end
  end

  assign stat_o.drive    = drive_d;
  assign stat_o.active   = active_d;
  assign stat_o.accepted = accept;

endmodule

// ===== rtl/coil_pulse_driver_with_holdoff.sv =====
// top level of the coil pulse driver: stream ports, config registers, result register
// depends on cpd_pkg and cpd_chan
//
// channel   direction  content
// s_axis    in         tdata: channel; tuser: kind
// m_axis    out        tdata: coil_drive, coil_active; tuser: fire_accepted
// cfg       in         write only: pulse_ticks, holdoff_ticks, quiet_mode
//
// one transaction per cycle unless m_axis stalls; result shows in the next cycle
// on a tick all channel counters update in parallel in the accepting cycle
// reset clears counters, drive bits and config registers to their defaults
// input is taken while the result register is empty or being drained
module coil_pulse_driver_with_holdoff import cpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [3:0] channel
  input  logic                 s_axis_tuser,   // [0] kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*MaskW-1:0]   m_axis_tdata,   // [15:0] coil_drive, [31:16] coil_active
  output logic                 m_axis_tuser,   // [0] fire_accepted
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CntW-1:0]      cfg_data_i
);

  logic [CntW-1:0]   pulse_ticks_q;
  logic [CntW-1:0]   holdoff_ticks_q;
  logic [QuietW-1:0] quiet_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ticks_q   <= PulseTicksRst;
      holdoff_ticks_q <= HoldoffTicksRst;
      quiet_mode_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPulseTicks:   pulse_ticks_q   <= cfg_data_i;
        CfgHoldoffTicks: holdoff_ticks_q <= cfg_data_i;
        CfgQuietMode:    quiet_mode_q    <= cfg_data_i[QuietW-1:0];
        default: ;
      endcase
    end
  end

  logic             out_valid_q;
  logic             step;
  logic [ChanW-1:0] chan;
  logic             kind;
  logic             quiet;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign chan          = s_axis_tdata[ChanW-1:0];
  assign kind          = s_axis_tuser;
  assign quiet         = (quiet_mode_q == QuietBlock);

  cpd_chan_stat_t      stat [NumCoils];
  logic [MaskW-1:0]    drive_d, active_d;
  logic                acc_d;

  for (genvar g = 0; g < NumCoils; g++) begin : g_chan
    cpd_chan_ctrl_t ctrl;
    assign ctrl.step    = step;
    assign ctrl.tick    = (kind == KindTick);
    assign ctrl.fire    = (kind == KindFire) && (chan == ChanW'(g));
    assign ctrl.blocked = quiet && (g < QuietChans);

    cpd_chan u_chan (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctrl_i          (ctrl),
      .pulse_ticks_i   (pulse_ticks_q),
      .holdoff_ticks_i (holdoff_ticks_q),
      .stat_o          (stat[g])
    );
  end

  always_comb begin
    drive_d  = '0;
    active_d = '0;
    acc_d    = 1'b0;
    for (int i = 0; i < NumCoils; i++) begin
      drive_d[i]  = stat[i].drive;
      active_d[i] = stat[i].active;
      acc_d       = acc_d | stat[i].accepted;
    end
  end

  logic [MaskW-1:0] drive_q, active_q;
  logic             acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      drive_q  <= drive_d;
      active_q <= active_d;
      acc_q    <= acc_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {active_q, drive_q};
  assign m_axis_tuser  = acc_q;

endmodule
